// ===== sv/fcba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_pkg: shared definitions for the chain block allocator
// Field widths, table markers, item kinds, result codes and the table entry
// layout used by the allocator and its memory.
// ----------------------------------------------------------------------------
package fcba_pkg;

  // Field widths of the stream words.
  localparam int KIND_W   = 2;
  localparam int SIZE_W   = 20;
  localparam int HANDLE_W = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int LINK_W   = 11;

  // Packed word widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Default geometry of the table.
  localparam int NUM_BLOCKS_DEF  = 1024;
  localparam int BLOCK_BYTES_DEF = 512;

  // Link values with a special meaning.
  localparam logic [LINK_W-1:0] FREE_MARK = 11'h7FF;
  localparam logic [LINK_W-1:0] END_MARK  = 11'h7FE;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2
  } fcba_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOSPACE   = 2'd1,
    ST_ZERO      = 2'd2,
    ST_BADHANDLE = 2'd3
  } fcba_status_e;

  // One table entry: chain head flag plus the link to the next block.
  typedef struct packed {
    logic              head;
    logic [LINK_W-1:0] link;
  } fcba_entry_t;

endpackage

// ===== sv/fcba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_ram: single-write, single-read synchronous table memory
// Read data is registered. A read of the address written in the same cycle
// returns the new data.
// ----------------------------------------------------------------------------
module fcba_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port with write forwarding.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fcba_ceil_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_ceil_div: ceiling division by a constant
// Two register stages. The first adds DIVISOR - 1 to the dividend, the second
// multiplies by a fixed reciprocal and shifts, which gives the exact quotient
// rounded up for every dividend that fits the field.
// ----------------------------------------------------------------------------
module fcba_ceil_div #(
  parameter int DIVISOR = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fcba_pkg::SIZE_W-1:0] dividend_i,
  output logic                        done_o,
  output logic [fcba_pkg::SIZE_W-1:0] quot_o
);

  import fcba_pkg::*;

  // The biased dividend needs one bit more than the size field. With the
  // shift set to that width plus the rounded-up log of the divisor, the
  // rounded-up reciprocal fits in one bit more again and the product equals
  // the floor quotient for every biased dividend.
  localparam int SUM_W  = SIZE_W + 1;
  localparam int SH     = SUM_W + $clog2(DIVISOR);
  localparam int RCP_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam logic [SUM_W-1:0] BIAS = SUM_W'(DIVISOR - 1);

  logic              s1_q;
  logic              done_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SIZE_W-1:0] quot_q;
  logic [PROD_W-1:0] prod;

  // Reciprocal multiplication of the biased dividend.
  assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      done_q <= s1_q;
    end
  end

  // Bias on start, then the scaled product.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= SUM_W'(dividend_i) + BIAS;
    end
    quot_q <= SIZE_W'(prod >> SH);
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== sv/fat_chain_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_block_allocator: chained block allocator over a link table
// Allocates chains of blocks by scanning the table for free entries, frees
// chains by walking their links, and clears the whole table on request.
// ----------------------------------------------------------------------------
// Channel     | Dir | Word contents (lowest bit first)
// s_axis      | in  | tdata: size_bytes[19:0], block_handle[29:20]; tuser: kind
// m_axis      | out | tdata: status[1:0], first_block[11:2], free_blocks[22:12]
//
// Allocate: the two-stage size conversion, then the scan of the table, one entry
// per cycle from the memory read port.
// Free: a walk of the chain, one link per cycle through the port.
// Clear, and the pass after reset: one entry per cycle; no word is taken
// during that pass.
// One item is in work at a time. A finished result waits in the output
// register, and a new word is taken while it is not yet taken.
// ----------------------------------------------------------------------------
module fat_chain_block_allocator #(
  parameter int NUM_BLOCKS  = fcba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = fcba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // size_bytes, block_handle
  input  logic [fcba_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [fcba_pkg::KIND_W-1:0]      s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // status, first_block, free_blocks
  output logic [fcba_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready
);

  import fcba_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam logic [AW:0]        NB_IDX  = (AW + 1)'(NUM_BLOCKS);
  localparam logic [COUNT_W-1:0] NB_CNT  = COUNT_W'(NUM_BLOCKS);
  localparam logic [COUNT_W:0]   NB_WIDE = (COUNT_W + 1)'(NUM_BLOCKS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_SCAN_END,
    S_WALK,
    S_FINISH
  } state_e;

  state_e             state_q, state_d;
  logic [AW:0]        clr_idx_q, clr_idx_d;
  logic               clr_reply_q, clr_reply_d;
  logic [COUNT_W-1:0] free_q, free_d;
  logic [COUNT_W-1:0] need_q, need_d;
  logic [AW:0]        rd_idx_q, rd_idx_d;
  logic [AW-1:0]      chk_idx_q, chk_idx_d;
  logic               chk_vld_q, chk_vld_d;
  logic               have_first_q, have_first_d;
  logic [AW-1:0]      first_q, first_d;
  logic [AW-1:0]      prev_q, prev_d;
  logic               prev_first_q, prev_first_d;
  logic [AW-1:0]      cur_q, cur_d;
  logic [AW:0]        steps_q, steps_d;
  logic [COUNT_W-1:0] freed_q, freed_d;
  logic               walk_first_q, walk_first_d;
  fcba_status_e       res_status_q, res_status_d;
  logic [HANDLE_W-1:0] res_first_q, res_first_d;
  logic               m_valid_q, m_valid_d;
  fcba_status_e       m_status_q, m_status_d;
  logic [HANDLE_W-1:0] m_first_q, m_first_d;
  logic [COUNT_W-1:0] m_free_q, m_free_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  fcba_entry_t         ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  fcba_entry_t         ram_rdata;
  logic                div_start;
  logic                div_done;
  logic [SIZE_W-1:0]   div_quot;
  logic [SIZE_W-1:0]   in_size;
  logic [HANDLE_W-1:0] in_handle;
  logic [COUNT_W:0]    walk_total;
  logic                walk_stop;

  assign in_size   = s_axis_tdata[SIZE_W-1:0];
  assign in_handle = s_axis_tdata[SIZE_W+HANDLE_W-1:SIZE_W];

  // Link table with head flags.
  fcba_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH ($bits(fcba_entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Byte size to block count.
  fcba_ceil_div #(
    .DIVISOR (BLOCK_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_size),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_free_q, m_first_q, m_status_q};

  // Sequencer: clear pass, allocation scan, chain walk and result hand-off.
  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    clr_reply_d  = clr_reply_q;
    free_d       = free_q;
    need_d       = need_q;
    rd_idx_d     = rd_idx_q;
    chk_idx_d    = chk_idx_q;
    chk_vld_d    = chk_vld_q;
    have_first_d = have_first_q;
    first_d      = first_q;
    prev_d       = prev_q;
    prev_first_d = prev_first_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    freed_d      = freed_q;
    walk_first_d = walk_first_q;
    res_status_d = res_status_q;
    res_first_d  = res_first_q;
    m_valid_d    = m_valid_q;
    m_status_d   = m_status_q;
    m_first_d    = m_first_q;
    m_free_d     = m_free_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '{head: 1'b0, link: FREE_MARK};
    ram_re       = 1'b0;
    ram_raddr    = '0;
    div_start    = 1'b0;
    walk_total   = '0;
    walk_stop    = 1'b0;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q[AW-1:0];
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == NB_IDX - 1'b1) begin
          free_d      = NB_CNT;
          clr_reply_d = 1'b0;
          res_status_d = ST_OK;
          res_first_d  = '0;
          state_d      = clr_reply_q ? S_FINISH : S_IDLE;
        end
      end

      S_IDLE: begin
        res_first_d = '0;
        if (s_axis_tvalid) begin
          case (fcba_kind_e'(s_axis_tuser))
            KIND_ALLOC: begin
              if (in_size == '0) begin
                res_status_d = ST_ZERO;
                state_d      = S_FINISH;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            KIND_FREE: begin
              if ((COUNT_W + 1)'(in_handle) >= NB_WIDE) begin
                res_status_d = ST_BADHANDLE;
                state_d      = S_FINISH;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = AW'(in_handle);
                cur_d        = AW'(in_handle);
                steps_d      = '0;
                freed_d      = '0;
                walk_first_d = 1'b1;
                state_d      = S_WALK;
              end
            end
            KIND_CLEAR: begin
              clr_idx_d   = '0;
              clr_reply_d = 1'b1;
              state_d     = S_CLEAR;
            end
            default: begin
              res_status_d = ST_OK;
              state_d      = S_FINISH;
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          if (SIZE_W'(free_q) < div_quot) begin
            res_status_d = ST_NOSPACE;
            state_d      = S_FINISH;
          end else begin
            free_d       = free_q - COUNT_W'(div_quot);
            need_d       = COUNT_W'(div_quot);
            rd_idx_d     = '0;
            chk_vld_d    = 1'b0;
            have_first_d = 1'b0;
            state_d      = S_SCAN;
          end
        end
      end

      // Reads run one entry ahead of the check. A found entry links the
      // previous one to it; the last one gets its end marker afterwards.
      S_SCAN: begin
        if (chk_vld_q && (ram_rdata.link == FREE_MARK)) begin
          if (have_first_q) begin
            ram_we    = 1'b1;
            ram_waddr = prev_q;
            ram_wdata = '{head: prev_first_q, link: LINK_W'(chk_idx_q)};
          end else begin
            first_d = chk_idx_q;
          end
          prev_d       = chk_idx_q;
          prev_first_d = !have_first_q;
          have_first_d = 1'b1;
          need_d       = need_q - 1'b1;
        end
        if (chk_vld_q && (ram_rdata.link == FREE_MARK) && (need_q == COUNT_W'(1))) begin
          state_d = S_SCAN_END;
        end else if (rd_idx_q < NB_IDX) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q[AW-1:0];
          chk_idx_d = rd_idx_q[AW-1:0];
          chk_vld_d = 1'b1;
          rd_idx_d  = rd_idx_q + 1'b1;
        end else begin
          chk_vld_d = 1'b0;
          if (!chk_vld_q) begin
            state_d = S_SCAN_END;
          end
        end
      end

      S_SCAN_END: begin
        if (have_first_q) begin
          ram_we       = 1'b1;
          ram_waddr    = prev_q;
          ram_wdata    = '{head: prev_first_q, link: END_MARK};
          res_status_d = ST_OK;
          res_first_d  = HANDLE_W'(first_q);
        end else begin
          res_status_d = ST_NOSPACE;
          res_first_d  = '0;
        end
        state_d = S_FINISH;
      end

      // Each cycle frees the current entry and, until the walk stops, reads the next link.
      S_WALK: begin
        if (walk_first_q && !ram_rdata.head) begin
          res_status_d = ST_BADHANDLE;
          state_d      = S_FINISH;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cur_q;
          if (ram_rdata.link != FREE_MARK) begin
            freed_d = freed_q + 1'b1;
          end
          walk_stop = (ram_rdata.link == FREE_MARK) || (ram_rdata.link == END_MARK) ||
                      ((COUNT_W + 1)'(ram_rdata.link) >= NB_WIDE) ||
                      (steps_q + 1'b1 == NB_IDX);
          if (walk_stop) begin
            walk_total   = (COUNT_W + 1)'(free_q) + (COUNT_W + 1)'(freed_d);
            free_d       = (walk_total > NB_WIDE) ? NB_CNT : COUNT_W'(walk_total);
            res_status_d = ST_OK;
            state_d      = S_FINISH;
          end else begin
            ram_re       = 1'b1;
            ram_raddr    = AW'(ram_rdata.link);
            cur_d        = AW'(ram_rdata.link);
            steps_d      = steps_q + 1'b1;
            walk_first_d = 1'b0;
          end
        end
      end

      S_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_first_d  = res_first_q;
          m_free_d   = free_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_idx_q    <= '0;
      clr_reply_q  <= 1'b0;
      free_q       <= NB_CNT;
      m_valid_q    <= 1'b0;
      chk_vld_q    <= 1'b0;
      have_first_q <= 1'b0;
      walk_first_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_idx_q    <= clr_idx_d;
      clr_reply_q  <= clr_reply_d;
      free_q       <= free_d;
      m_valid_q    <= m_valid_d;
      chk_vld_q    <= chk_vld_d;
      have_first_q <= have_first_d;
      walk_first_q <= walk_first_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    need_q       <= need_d;
    rd_idx_q     <= rd_idx_d;
    chk_idx_q    <= chk_idx_d;
    first_q      <= first_d;
    prev_q       <= prev_d;
    prev_first_q <= prev_first_d;
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    freed_q      <= freed_d;
    res_status_q <= res_status_d;
    res_first_q  <= res_first_d;
    m_status_q   <= m_status_d;
    m_first_q    <= m_first_d;
    m_free_q     <= m_free_d;
  end

  // The free count never exceeds the table size.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= NB_CNT)
    else $error("free count above table size");

  // Only one item is in work: an accepted word blocks the next one.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word accepted during work");

  // The table is never written while waiting for a word.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("table write while idle");

  // A running scan always has blocks left to find.
  a_scan_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (need_q != '0))
    else $error("scan running with nothing left to allocate");

  // A chain walk stays within the step limit.
  a_walk_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (steps_q < NB_IDX))
    else $error("chain walk past step limit");

endmodule

// ===== tb/fat_chain_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_block_allocator_tb: self-checking bench for the chain allocator
// Drives allocate, free, clear and unused-kind words into the allocator.
// A shadow copy of the link table predicts every reply, and each reply word
// is checked field by field in order. The run uses directed corner cases
// first, then random traffic with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module fat_chain_block_allocator_tb;
  import fcba_pkg::*;

  localparam int NUM_BLOCKS  = NUM_BLOCKS_DEF;
  localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;

  // The kind code that the allocator has no operation for.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Cycles to wait after the last reply; one allocate scan plus margin.
  localparam int DRAIN_CYCLES = NUM_BLOCKS + 100;
  localparam int HOLD_CYCLES  = 4000;
  localparam int RANDOM_OPS   = 280;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [SIZE_W-1:0]   size_bytes;
    logic [HANDLE_W-1:0] handle;
    int                  gap;
  } table_op_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] first_block;
    logic [COUNT_W-1:0]  free_blocks;
  } alloc_reply_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]      s_axis_tuser  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   hold_rx       = 1'b0;

  // Shadow state of the allocator.
  logic [LINK_W-1:0]  link_tab [NUM_BLOCKS];
  bit                 head_tab [NUM_BLOCKS];
  logic [COUNT_W-1:0] free_cnt;
  int                 live_heads[$];

  table_op_t    op_queue[$];
  table_op_t    op_on_bus;
  alloc_reply_t predicted_replies[$];

  int ops_queued    = 0;
  int ops_accepted  = 0;
  int replies_seen  = 0;
  int mismatch_cnt  = 0;
  int wait_cycles   = 0;
  int rx_wait       = 0;

  fat_chain_block_allocator #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Return every entry to the free pool and drop all chain heads.
  function automatic void clear_shadow();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      link_tab[i] = FREE_MARK;
      head_tab[i] = 1'b0;
    end
    free_cnt = COUNT_W'(NUM_BLOCKS);
    live_heads.delete();
  endfunction

  // Apply one operation to the shadow table and return the reply it earns.
  function automatic alloc_reply_t apply_table_op(table_op_t op);
    alloc_reply_t rep;
    int unsigned  need;
    int unsigned  prev;
    int unsigned  first;
    int unsigned  cur;
    int unsigned  freed;
    int unsigned  link;
    int unsigned  total;
    bit           have_first;
    rep.status      = ST_OK;
    rep.first_block = '0;
    case (op.kind)
      KIND_ALLOC: begin
        need = op.size_bytes / BLOCK_BYTES + ((op.size_bytes % BLOCK_BYTES) != 0 ? 1 : 0);
        if (op.size_bytes == 0) begin
          rep.status = ST_ZERO;
        end else if (free_cnt < need) begin
          rep.status = ST_NOSPACE;
        end else begin
          free_cnt   = free_cnt - COUNT_W'(need);
          have_first = 1'b0;
          prev       = 0;
          first      = 0;
          for (int i = 0; i < NUM_BLOCKS && need != 0; i++) begin
            if (link_tab[i] == FREE_MARK) begin
              if (!have_first) begin
                first      = i;
                have_first = 1'b1;
              end else begin
                link_tab[prev] = LINK_W'(i);
              end
              prev        = i;
              need--;
              link_tab[i] = END_MARK;
            end
          end
          if (!have_first) begin
            rep.status = ST_NOSPACE;
          end else begin
            head_tab[first] = 1'b1;
            live_heads.push_back(first);
            rep.first_block = HANDLE_W'(first);
          end
        end
      end
      KIND_FREE: begin
        if (op.handle >= NUM_BLOCKS || !head_tab[op.handle]) begin
          rep.status = ST_BADHANDLE;
        end else begin
          head_tab[op.handle] = 1'b0;
          foreach (live_heads[i]) begin
            if (live_heads[i] == op.handle) begin
              live_heads.delete(i);
              break;
            end
          end
          // Walk the chain; a damaged chain ends the walk early.
          cur   = 32'(op.handle);
          freed = 0;
          for (int steps = 0; steps < NUM_BLOCKS; steps++) begin
            link = 32'(link_tab[cur]);
            if (link == FREE_MARK) break;
            link_tab[cur] = FREE_MARK;
            freed++;
            if (link == END_MARK || link >= NUM_BLOCKS) break;
            cur = link;
          end
          total    = free_cnt + freed;
          free_cnt = COUNT_W'(total > NUM_BLOCKS ? NUM_BLOCKS : total);
        end
      end
      KIND_CLEAR: begin
        clear_shadow();
      end
      default: begin
      end
    endcase
    rep.free_blocks = free_cnt;
    return rep;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("ERROR reply %0d %s: got 0x%0h, expected 0x%0h", replies_seen, field, got, want);
    mismatch_cnt++;
  endtask

  // Compare one reply word with the oldest prediction.
  task automatic check_reply(logic [OUT_TDATA_W-1:0] word);
    alloc_reply_t want;
    if (predicted_replies.size() == 0) begin
      report_mismatch("unexpected word", 32'(word), 0);
    end else begin
      want = predicted_replies.pop_front();
      if (word[1:0] !== want.status)
        report_mismatch("status", 32'(word[1:0]), 32'(want.status));
      if (word[11:2] !== want.first_block)
        report_mismatch("first_block", 32'(word[11:2]), 32'(want.first_block));
      if (word[22:12] !== want.free_blocks)
        report_mismatch("free_blocks", 32'(word[22:12]), 32'(want.free_blocks));
    end
  endtask

  // Hand one operation to the driver, keeping only a short backlog so that
  // random choices see a recent view of the shadow table.
  task automatic queue_op(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] size_bytes,
                          logic [HANDLE_W-1:0] handle);
    table_op_t op;
    while (op_queue.size() >= 2) @(posedge clk_i);
    op.kind       = kind;
    op.size_bytes = size_bytes;
    op.handle     = handle;
    op.gap        = ((ops_queued / 40) % 4 == 3) ? 0 : $urandom_range(0, 16);
    op_queue.push_back(op);
    ops_queued++;
  endtask

  // Hold the sender until every word is taken and every reply is back.
  task automatic wait_all_replied();
    while (!(op_queue.size() == 0 && !s_axis_tvalid && predicted_replies.size() == 0))
      @(posedge clk_i);
  endtask

  // Pick one random operation, biased toward well-formed traffic.
  task automatic queue_random_op();
    int unsigned         pick;
    int unsigned         span;
    logic [SIZE_W-1:0]   size_bytes;
    logic [HANDLE_W-1:0] handle;
    pick       = $urandom_range(0, 99);
    size_bytes = SIZE_W'($urandom);
    handle     = HANDLE_W'($urandom);
    if (pick < 45 || pick >= 91) begin
      span = $urandom_range(0, 99);
      if (pick >= 91)
        size_bytes = SIZE_W'($urandom_range(1, 1024));
      else if (span < 4)
        size_bytes = '0;
      else if (span < 50)
        size_bytes = SIZE_W'($urandom_range(1, 2048));
      else if (span < 75)
        size_bytes = SIZE_W'($urandom_range(1, 16384));
      else if (span < 85)
        size_bytes = SIZE_W'($urandom_range(1, NUM_BLOCKS * BLOCK_BYTES));
      else if (span < 90)
        size_bytes = SIZE_W'($urandom_range(NUM_BLOCKS * BLOCK_BYTES + 1, (1 << SIZE_W) - 1));
      else begin
        // Sizes around the remaining free space: exact fit, one byte over, or up to 511 bytes under.
        case ($urandom_range(0, 2))
          0: size_bytes = SIZE_W'(free_cnt * BLOCK_BYTES);
          1: size_bytes = SIZE_W'(free_cnt * BLOCK_BYTES + 1);
          default: size_bytes = SIZE_W'(free_cnt * BLOCK_BYTES - $urandom_range(0, 511));
        endcase
        if (free_cnt == 0) size_bytes = SIZE_W'($urandom_range(1, 2));
      end
      queue_op(KIND_ALLOC, size_bytes, handle);
    end else if (pick < 85) begin
      if (live_heads.size() != 0 && $urandom_range(0, 9) < 8)
        handle = HANDLE_W'(live_heads[$urandom_range(0, live_heads.size() - 1)]);
      queue_op(KIND_FREE, size_bytes, handle);
    end else if (pick < 88) begin
      queue_op(KIND_UNUSED, size_bytes, handle);
    end else begin
      queue_op(KIND_CLEAR, size_bytes, handle);
    end
  endtask

  // Sender: present queued words after their idle gap, predict on accept.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      wait_cycles   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_replies.push_back(apply_table_op(op_on_bus));
        ops_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (op_queue.size() != 0 && wait_cycles >= op_queue[0].gap) begin
          op_on_bus     = op_queue.pop_front();
          s_axis_tdata  <= {2'b00, op_on_bus.handle, op_on_bus.size_bytes};
          s_axis_tuser  <= op_on_bus.kind;
          s_axis_tvalid <= 1'b1;
          wait_cycles   = 0;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (op_queue.size() != 0) wait_cycles++;
        end
      end
    end
  end

  // Receiver: take reply words with random stalls and check each one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_reply(m_axis_tdata);
        replies_seen++;
        rx_wait = ((replies_seen / 50) % 4 == 3) ? 0 : $urandom_range(0, 16);
      end
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
      end else if (rx_wait != 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the allocator fills up and stalls its input.
  initial begin
    wait (ops_accepted >= 80);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Overall time limit.
  initial begin
    #6000000;
    $display("fat_chain_block_allocator_tb failed");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    clear_shadow();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corner cases.
    queue_op(KIND_ALLOC, 20'd0, '0);         // zero size
    queue_op(KIND_ALLOC, 20'd1, '0);         // one byte, one block
    queue_op(KIND_ALLOC, 20'd512, '0);       // exactly one block
    queue_op(KIND_ALLOC, 20'd513, '0);       // one byte over, two blocks
    queue_op(KIND_FREE, '0, 10'd1);          // free a chain, leaving a hole
    queue_op(KIND_FREE, '0, 10'd1);          // same handle again
    queue_op(KIND_FREE, '0, 10'd3);          // block inside a chain, not a head
    queue_op(KIND_ALLOC, 20'd1024, '0);      // fills the hole, then goes on
    queue_op(KIND_FREE, '0, 10'h3FF);        // never allocated, top handle
    queue_op(KIND_UNUSED, 20'hFFFFF, 10'h3FF);
    queue_op(KIND_ALLOC, 20'd524288, '0);    // whole table while some is used
    queue_op(KIND_CLEAR, '0, '0);
    queue_op(KIND_ALLOC, 20'd524288, '0);    // needs exactly the free count
    queue_op(KIND_ALLOC, 20'd1, '0);         // table is full
    queue_op(KIND_FREE, '0, 10'd0);          // walks the full-length chain
    queue_op(KIND_ALLOC, 20'hFFFFF, '0);     // largest field value
    queue_op(KIND_ALLOC, 20'd524287, '0);
    queue_op(KIND_FREE, '0, 10'd0);
    queue_op(KIND_FREE, '0, 10'd0);          // already freed
    queue_op(KIND_ALLOC, 20'd511, '0);
    queue_op(KIND_CLEAR, 20'hFFFFF, 10'h3FF);
    queue_op(KIND_FREE, '0, 10'd0);          // head gone after the clear
    wait_all_replied();

    // Two random phases with a full pause of the sender between them.
    for (int phase = 0; phase < 2; phase++) begin
      for (int n = 0; n < RANDOM_OPS; n++) queue_random_op();
      wait_all_replied();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && predicted_replies.size() == 0) begin
      $display("fat_chain_block_allocator_tb passed");
    end else begin
      $display("fat_chain_block_allocator_tb failed");
    end
    $finish;
  end

endmodule
